/* rtl/tsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp pacer package
// Shared widths, codes, register indexes and state types of the pacer.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int STAMP_W     = 64;
    localparam int CFG_W       = 40;
    localparam int OUT_CNT_W   = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int COUNT_WIDTH = 32;

    localparam logic [CFG_W-1:0] DEFAULT_QUANTUM = CFG_W'(10000000);

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] TOLERANCE_RST = CFG_W'(1000000);
    localparam logic [CFG_W-1:0] JUMP_RST      = CFG_W'(1000000000);
    localparam logic [CFG_W-1:0] MAX_LATE_RST  = '0;
    localparam logic [CFG_W-1:0] QUANTUM_RST   = CFG_W'(10000000);

    typedef enum logic {
        OP_PACE   = 1'b0,
        OP_REBASE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        DEC_RELEASE = 2'd0,
        DEC_WAIT    = 2'd1,
        DEC_DROP    = 2'd2
    } decision_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 3'd0,
        REG_TOLERANCE = 3'd1,
        REG_JUMP      = 3'd2,
        REG_MAX_LATE  = 3'd3,
        REG_QUANTUM   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic               enable;
        logic [CFG_W-1:0]   tolerance;
        logic [CFG_W-1:0]   jump_threshold;
        logic [CFG_W-1:0]   max_late;
        logic [CFG_W-1:0]   sleep_quantum;
    } cfg_t;

    typedef struct packed {
        logic                   started;
        logic [STAMP_W-1:0]     base_stamp;
        logic [STAMP_W-1:0]     base_time;
        logic [STAMP_W-1:0]     last_stamp;
        logic [COUNT_WIDTH-1:0] paced_cnt;
        logic [COUNT_WIDTH-1:0] dropped_cnt;
        logic [COUNT_WIDTH-1:0] reset_cnt;
        logic [STAMP_W-1:0]     wait_sum;
    } pace_state_t;

endpackage

/* rtl/tsp_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pace item channel
// Valid/ready channel carrying one pace or rebase request per item.
// ----------------------------------------------------------------------------
interface tsp_item_if;
    import tsp_pkg::*;

    logic                valid;
    logic                ready;
    opcode_t             opcode;
    logic [STAMP_W-1:0]  stamp;
    logic [STAMP_W-1:0]  now_time;

    modport source (output valid, output opcode, output stamp, output now_time,
                    input ready);
    modport sink   (input valid, input opcode, input stamp, input now_time,
                    output ready);
endinterface

/* rtl/tsp_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pace result channel
// Valid/ready channel carrying one decision and the running totals per item.
// ----------------------------------------------------------------------------
interface tsp_result_if;
    import tsp_pkg::*;

    logic                  valid;
    logic                  ready;
    decision_t             decision;
    logic [CFG_W-1:0]      sleep_len;
    logic [OUT_CNT_W-1:0]  paced_total;
    logic [OUT_CNT_W-1:0]  dropped_total;
    logic [OUT_CNT_W-1:0]  reset_total;
    logic [STAMP_W-1:0]    waited_total;

    modport source (output valid, output decision, output sleep_len,
                    output paced_total, output dropped_total, output reset_total,
                    output waited_total, input ready);
    modport sink   (input valid, input decision, input sleep_len,
                    input paced_total, input dropped_total, input reset_total,
                    input waited_total, output ready);
endinterface

/* rtl/tsp_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface tsp_cfg_if;
    import tsp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/tsp_decide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pacing decision
// Combinational decision for one item: release, wait or drop, plus the
// updated pacing base and counters.
// ----------------------------------------------------------------------------
module tsp_decide (
    input  tsp_pkg::cfg_t                 cfg,
    input  tsp_pkg::pace_state_t          st,
    input  tsp_pkg::opcode_t              opcode,
    input  logic [tsp_pkg::STAMP_W-1:0]   stamp,
    input  logic [tsp_pkg::STAMP_W-1:0]   now_time,
    output tsp_pkg::pace_state_t          st_next,
    output tsp_pkg::decision_t            decision,
    output logic [tsp_pkg::CFG_W-1:0]     sleep_len
);
    import tsp_pkg::*;

    logic [STAMP_W-1:0] gap;
    logic               jump;
    logic               rebase;
    logic [STAMP_W-1:0] delta;
    logic [STAMP_W:0]   target_sum;
    logic [STAMP_W-1:0] target;
    logic [STAMP_W-1:0] late;
    logic [STAMP_W-1:0] early;
    logic               too_late;
    logic               too_early;
    logic [CFG_W-1:0]   quantum;
    logic [CFG_W-1:0]   sleep_amt;

    // Rebase conditions: not started, backward stamp, or large forward jump.
    assign gap    = stamp - st.last_stamp;
    assign jump   = (cfg.jump_threshold != '0) && (stamp > st.last_stamp) &&
                    (gap > STAMP_W'(cfg.jump_threshold));
    assign rebase = !st.started || (stamp < st.last_stamp) || jump;

    // Target clock time, saturated at the top of the range.
    assign delta      = stamp - st.base_stamp;
    assign target_sum = {1'b0, st.base_time} + {1'b0, delta};
    assign target     = target_sum[STAMP_W] ? '1 : target_sum[STAMP_W-1:0];

    // Lateness and earliness against the current clock reading.
    assign late      = now_time - target;
    assign early     = target - now_time;
    assign too_late  = (now_time > target) && (cfg.max_late != '0) &&
                       (late > STAMP_W'(cfg.max_late));
    assign too_early = (target > now_time) && (early > STAMP_W'(cfg.tolerance));

    // One sleep is the lesser of the remaining wait and the quantum.
    assign quantum   = (cfg.sleep_quantum != '0) ? cfg.sleep_quantum : DEFAULT_QUANTUM;
    assign sleep_amt = (early < STAMP_W'(quantum)) ? early[CFG_W-1:0] : quantum;

    always_comb
    begin
        st_next   = st;
        decision  = DEC_RELEASE;
        sleep_len = '0;
        if (opcode == OP_REBASE)
        begin
            st_next.started    = 1'b0;
            st_next.base_stamp = '0;
            st_next.base_time  = '0;
            st_next.last_stamp = '0;
            st_next.reset_cnt  = st.reset_cnt + 1'b1;
        end
        else if (cfg.enable)
        begin
            if (rebase || (stamp != st.last_stamp && stamp < st.base_stamp))
            begin
                // Every rebase cause, a stamp below the base among them, counts a reset
                // only once pacing has started.
                if (st.started)
                begin
                    st_next.reset_cnt = st.reset_cnt + 1'b1;
                end
                st_next.started    = 1'b1;
                st_next.base_stamp = stamp;
                st_next.base_time  = now_time;
                st_next.last_stamp = stamp;
                st_next.paced_cnt  = st.paced_cnt + 1'b1;
            end
            else if (stamp == st.last_stamp)
            begin
                st_next.paced_cnt = st.paced_cnt + 1'b1;
            end
            else if (too_late)
            begin
                st_next.last_stamp  = stamp;
                st_next.dropped_cnt = st.dropped_cnt + 1'b1;
                decision            = DEC_DROP;
            end
            else if (too_early)
            begin
                st_next.wait_sum = st.wait_sum + STAMP_W'(sleep_amt);
                decision         = DEC_WAIT;
                sleep_len        = sleep_amt;
            end
            else
            begin
                st_next.last_stamp = stamp;
                st_next.paced_cnt  = st.paced_cnt + 1'b1;
            end
        end
    end

endmodule

/* rtl/timestamp_pacer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp pacer
// Paces media timestamps against a clock reading and answers each item with
// release, wait (with a sleep length) or drop, plus running totals.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready input; opcode pace or rebase, stamp, now_time.
//   result : valid/ready output; one result item for every input item.
//   cfg    : valid/ready register writes, always ready; write only while idle.
// An accepted item sits in the input register, the decision is computed
// combinationally from it and the pacing state, and the result register
// loads the outcome once it can take a new result. Throughput is one item per cycle
// while the receiver does not stall. The pacing state is updated at the same
// edge that loads the result, so the next item already sees it; that single
// decide path (a few 64-bit subtracts and compares) sets the cycle.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that item ready drops until the result
// drains.
// Reset clears the pacing base, the counters and both valid flags and loads
// the configuration defaults (pacing disabled).
// ----------------------------------------------------------------------------
module timestamp_pacer (
    input  logic          clk,
    input  logic          rst_n,
    tsp_item_if.sink      item,
    tsp_result_if.source  result,
    tsp_cfg_if.sink       cfg
);
    import tsp_pkg::*;

    cfg_t               cfg_reg;
    pace_state_t        st_reg;
    pace_state_t        st_next;

    logic               in_valid_reg;
    opcode_t            in_opcode_reg;
    logic [STAMP_W-1:0] in_stamp_reg;
    logic [STAMP_W-1:0] in_now_reg;

    logic               out_valid_reg;
    decision_t          out_decision_reg;
    logic [CFG_W-1:0]   out_sleep_reg;
    logic [OUT_CNT_W-1:0] out_paced_reg;
    logic [OUT_CNT_W-1:0] out_dropped_reg;
    logic [OUT_CNT_W-1:0] out_reset_reg;
    logic [STAMP_W-1:0] out_waited_reg;

    decision_t          dec;
    logic [CFG_W-1:0]   sleep_len;
    logic               fire;

    // The held item is decided when the result register can take it.
    assign fire       = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || fire;
    assign cfg.ready  = 1'b1;

    tsp_decide u_decide (
        .cfg      (cfg_reg),
        .st       (st_reg),
        .opcode   (in_opcode_reg),
        .stamp    (in_stamp_reg),
        .now_time (in_now_reg),
        .st_next  (st_next),
        .decision (dec),
        .sleep_len(sleep_len)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_opcode_reg <= item.opcode;
            in_stamp_reg  <= item.stamp;
            in_now_reg    <= item.now_time;
        end
    end

    // Configuration registers and pacing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.tolerance      <= TOLERANCE_RST;
            cfg_reg.jump_threshold <= JUMP_RST;
            cfg_reg.max_late       <= MAX_LATE_RST;
            cfg_reg.sleep_quantum  <= QUANTUM_RST;
            st_reg                 <= '0;
        end
        else
        begin
            if (fire)
            begin
                st_reg <= st_next;
            end
            if (cfg.valid)
            begin
                unique case (reg_index_t'(cfg.index))
                    REG_ENABLE:
                    begin
                        cfg_reg.enable <= cfg.data[0];
                        if (!cfg.data[0])
                        begin
                            st_reg.started <= 1'b0;
                        end
                    end
                    REG_TOLERANCE: cfg_reg.tolerance      <= cfg.data;
                    REG_JUMP:      cfg_reg.jump_threshold <= cfg.data;
                    REG_MAX_LATE:  cfg_reg.max_late       <= cfg.data;
                    REG_QUANTUM:   cfg_reg.sleep_quantum  <= cfg.data;
                    default:       ;
                endcase
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_decision_reg <= dec;
            out_sleep_reg    <= sleep_len;
            out_paced_reg    <= OUT_CNT_W'(st_next.paced_cnt);
            out_dropped_reg  <= OUT_CNT_W'(st_next.dropped_cnt);
            out_reset_reg    <= OUT_CNT_W'(st_next.reset_cnt);
            out_waited_reg   <= st_next.wait_sum;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.decision      = out_decision_reg;
    assign result.sleep_len     = out_sleep_reg;
    assign result.paced_total   = out_paced_reg;
    assign result.dropped_total = out_dropped_reg;
    assign result.reset_total   = out_reset_reg;
    assign result.waited_total  = out_waited_reg;

endmodule

/* rtl/tsp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp pacer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tsp_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [1:0]                   decision,
    input  logic [tsp_pkg::CFG_W-1:0]    sleep_len,
    input  logic [tsp_pkg::STAMP_W-1:0]  waited_total
);
    import tsp_pkg::*;

    // A stalled result keeps its decision and its waited total.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(decision) && $stable(waited_total))
        else $error("stalled result changed");

    // Only the three defined decisions appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> decision == DEC_RELEASE || decision == DEC_WAIT ||
                      decision == DEC_DROP)
        else $error("undefined decision code");

    // Release and drop carry no sleep.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && decision != DEC_WAIT |-> sleep_len == '0)
        else $error("sleep length on a non-wait result");

    // A wait always asks for a nonzero sleep.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && decision == DEC_WAIT |-> sleep_len != '0)
        else $error("wait result with zero sleep");

endmodule

bind timestamp_pacer tsp_checker u_tsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .decision    (result.decision),
    .sleep_len   (result.sleep_len),
    .waited_total(result.waited_total)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp pacer testbench
// Sends pace and rebase items through the valid/ready item channel, writes
// the pacing registers between phases, and checks every result item field by
// field against a scoreboard that keeps its own copy of the pacing state.
// A short directed part is followed by random pacing streams with retries,
// broken sequences and noise, under three idling patterns.
// ----------------------------------------------------------------------------
module testbench;
    import tsp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // One expected or observed result item.
    typedef struct {
        decision_t              decision;
        logic [CFG_W-1:0]       sleep_len;
        logic [OUT_CNT_W-1:0]   paced_total;
        logic [OUT_CNT_W-1:0]   dropped_total;
        logic [OUT_CNT_W-1:0]   reset_total;
        logic [STAMP_W-1:0]     waited_total;
    } pace_result_t;

    // Scoreboard: predicts the decision for each accepted item from its own
    // copy of the configuration and pacing state, and checks results in order.
    class pace_scoreboard;
        logic                   enable;
        logic [CFG_W-1:0]       tolerance;
        logic [CFG_W-1:0]       jump_threshold;
        logic [CFG_W-1:0]       max_late;
        logic [CFG_W-1:0]       sleep_quantum;
        logic                   started;
        logic [STAMP_W-1:0]     base_stamp;
        logic [STAMP_W-1:0]     base_time;
        logic [STAMP_W-1:0]     last_stamp;
        logic [STAMP_W-1:0]     wait_sum;
        logic [COUNT_WIDTH-1:0] paced_cnt;
        logic [COUNT_WIDTH-1:0] dropped_cnt;
        logic [COUNT_WIDTH-1:0] reset_cnt;
        pace_result_t           expected_q[$];
        decision_t              last_decision;
        logic [CFG_W-1:0]       last_sleep;
        int                     errors;

        function new();
            enable         = 1'b0;
            tolerance      = TOLERANCE_RST;
            jump_threshold = JUMP_RST;
            max_late       = MAX_LATE_RST;
            sleep_quantum  = QUANTUM_RST;
            started        = 1'b0;
            base_stamp     = '0;
            base_time      = '0;
            last_stamp     = '0;
            wait_sum       = '0;
            paced_cnt      = '0;
            dropped_cnt    = '0;
            reset_cnt      = '0;
            last_decision  = DEC_RELEASE;
            last_sleep     = '0;
            errors         = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_ENABLE:
                begin
                    enable = value[0];
                    if (!value[0])
                    begin
                        started = 1'b0;
                    end
                end
                REG_TOLERANCE: tolerance      = value;
                REG_JUMP:      jump_threshold = value;
                REG_MAX_LATE:  max_late       = value;
                REG_QUANTUM:   sleep_quantum  = value;
                default: ;
            endcase
        endfunction

        function void take_base(logic [STAMP_W-1:0] stamp, logic [STAMP_W-1:0] now);
            started    = 1'b1;
            base_stamp = stamp;
            base_time  = now;
            last_stamp = stamp;
        endfunction

        // Works out the result of one accepted item and queues it.
        function void note_item(opcode_t op, logic [STAMP_W-1:0] stamp,
                                logic [STAMP_W-1:0] now);
            pace_result_t       res;
            logic               rebase;
            logic [STAMP_W-1:0] delta;
            logic [STAMP_W-1:0] target;
            logic [STAMP_W-1:0] quantum;
            logic [STAMP_W-1:0] nap;

            res.decision  = DEC_RELEASE;
            res.sleep_len = '0;
            if (op == OP_REBASE)
            begin
                started    = 1'b0;
                base_stamp = '0;
                base_time  = '0;
                last_stamp = '0;
                reset_cnt  = reset_cnt + 1'b1;
            end
            else if (enable)
            begin
                rebase = !started || stamp < last_stamp ||
                         (jump_threshold != '0 && stamp > last_stamp &&
                          stamp - last_stamp > STAMP_W'(jump_threshold));
                delta  = stamp - base_stamp;
                // The target clock time saturates instead of wrapping.
                target = (STAMP_MAX - base_time < delta) ? STAMP_MAX : base_time + delta;
                if (rebase)
                begin
                    if (started)
                    begin
                        reset_cnt = reset_cnt + 1'b1;
                    end
                    take_base(stamp, now);
                    paced_cnt = paced_cnt + 1'b1;
                end
                else if (stamp == last_stamp)
                begin
                    paced_cnt = paced_cnt + 1'b1;
                end
                else if (stamp < base_stamp)
                begin
                    take_base(stamp, now);
                    reset_cnt = reset_cnt + 1'b1;
                    paced_cnt = paced_cnt + 1'b1;
                end
                else if (now > target && max_late != '0 &&
                         now - target > STAMP_W'(max_late))
                begin
                    last_stamp   = stamp;
                    dropped_cnt  = dropped_cnt + 1'b1;
                    res.decision = DEC_DROP;
                end
                else if (target > now && target - now > STAMP_W'(tolerance))
                begin
                    // Too early: sleep at most one quantum, keep last stamp.
                    quantum       = STAMP_W'((sleep_quantum != '0) ? sleep_quantum
                                                                   : DEFAULT_QUANTUM);
                    nap           = (target - now < quantum) ? target - now : quantum;
                    wait_sum      = wait_sum + nap;
                    res.decision  = DEC_WAIT;
                    res.sleep_len = nap[CFG_W-1:0];
                end
                else
                begin
                    last_stamp = stamp;
                    paced_cnt  = paced_cnt + 1'b1;
                end
            end
            res.paced_total   = paced_cnt[OUT_CNT_W-1:0];
            res.dropped_total = dropped_cnt[OUT_CNT_W-1:0];
            res.reset_total   = reset_cnt[OUT_CNT_W-1:0];
            res.waited_total  = wait_sum;
            last_decision     = res.decision;
            last_sleep        = res.sleep_len;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
            if (exp_val !== act_val)
            begin
                errors++;
                if (errors <= 100)
                begin
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, exp_val, act_val);
                end
            end
        endfunction

        // Checks one result item against the oldest expectation.
        function void check_result(pace_result_t got);
            pace_result_t exp_res;

            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result item with nothing expected, decision %0h",
                         $time, got.decision);
            end
            else
            begin
                exp_res = expected_q.pop_front();
                compare_field("decision", 64'(exp_res.decision), 64'(got.decision));
                compare_field("sleep_len", 64'(exp_res.sleep_len), 64'(got.sleep_len));
                compare_field("paced_total", 64'(exp_res.paced_total), 64'(got.paced_total));
                compare_field("dropped_total", 64'(exp_res.dropped_total),
                              64'(got.dropped_total));
                compare_field("reset_total", 64'(exp_res.reset_total), 64'(got.reset_total));
                compare_field("waited_total", exp_res.waited_total, got.waited_total);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tsp_item_if   item_ch ();
    tsp_result_if result_ch ();
    tsp_cfg_if    cfg_ch ();

    timestamp_pacer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    pace_scoreboard sb;
    int             send_idle;
    int             recv_idle;
    int             items_sent = 0;
    int             item_goal  = 0;
    int             cycle_cnt  = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("** timestamp_pacer: FAILED **");
            $finish;
        end
    end

    // Receiver side: ready changes at the falling edge.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = ($urandom_range(99) >= recv_idle);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        pace_result_t got;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.decision      = result_ch.decision;
            got.sleep_len     = result_ch.sleep_len;
            got.paced_total   = result_ch.paced_total;
            got.dropped_total = result_ch.dropped_total;
            got.reset_total   = result_ch.reset_total;
            got.waited_total  = result_ch.waited_total;
            sb.check_result(got);
        end
    end

    function automatic logic [STAMP_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CFG_W-1:0] rand40();
        return CFG_W'({$urandom, $urandom});
    endfunction

    // Presents one item, with random idle cycles first, and waits for it to
    // be taken. Valid stays high when the next item follows without a gap.
    task automatic send_item(opcode_t op, logic [STAMP_W-1:0] stamp,
                             logic [STAMP_W-1:0] now);
        while ($urandom_range(99) < send_idle)
        begin
            @(negedge clk);
            item_ch.valid = 1'b0;
        end
        @(negedge clk);
        item_ch.valid    = 1'b1;
        item_ch.opcode   = op;
        item_ch.stamp    = stamp;
        item_ch.now_time = now;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_item(op, stamp, now);
        items_sent++;
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Stops sending and waits until every expected result has come back,
    // then lets the two-stage pipeline empty.
    task automatic settle();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Picks a new register setting, the extremes among the choices.
    task automatic configure_random();
        logic [CFG_W-1:0] value;

        value    = rand40();
        value[0] = ($urandom_range(99) < 88);
        write_reg(REG_ENABLE, value);
        case ($urandom_range(4))
            0:       value = '0;
            1:       value = '1;
            2:       value = CFG_W'($urandom_range(0, 20000));
            default: value = CFG_W'($urandom_range(0, 2000000));
        endcase
        write_reg(REG_TOLERANCE, value);
        case ($urandom_range(4))
            0:       value = '0;
            1:       value = '1;
            2:       value = JUMP_RST;
            default: value = CFG_W'($urandom_range(1, 50000000));
        endcase
        write_reg(REG_JUMP, value);
        case ($urandom_range(4))
            0:       value = '0;
            1:       value = '1;
            2:       value = CFG_W'($urandom_range(1, 1000));
            default: value = CFG_W'($urandom_range(1, 5000000));
        endcase
        write_reg(REG_MAX_LATE, value);
        case ($urandom_range(5))
            0:       value = '0;
            1:       value = 40'd1;
            2:       value = '1;
            default: value = CFG_W'($urandom_range(1, 20000000));
        endcase
        write_reg(REG_QUANTUM, value);
    endtask

    // A well-formed media stream: stamps advance by a frame period and the
    // caller retries after each wait with its clock moved on by the sleep.
    // Now and then the stream goes backward, jumps, repeats or runs late.
    task automatic run_stream(int frames);
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] clock;
        int unsigned        period;
        int unsigned        pick;
        int                 tries;

        stamp  = rand64();
        clock  = ($urandom_range(1) == 0) ? rand64() : 64'($urandom);
        period = $urandom_range(1000, 30000000);
        for (int f = 0; f < frames && items_sent < item_goal; f++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                send_item(OP_REBASE, rand64(), rand64());
                stamp = stamp + 64'(period);
            end
            else if (pick < 6)
            begin
                stamp = stamp - 64'($urandom_range(1, 5000000));
            end
            else if (pick < 9)
            begin
                stamp = stamp + (64'($urandom_range(1, 8)) << 30);
            end
            else if (pick < 13)
            begin
                stamp = stamp + 64'(period);
                clock = clock + 64'($urandom_range(1000000, 60000000));
            end
            else if (pick >= 16)
            begin
                stamp = stamp + 64'(period);
            end
            send_item(OP_PACE, stamp, clock);
            tries = 0;
            while (sb.last_decision == DEC_WAIT && tries < 8)
            begin
                // Mostly wake after the full sleep; sometimes early.
                if ($urandom_range(7) == 0)
                begin
                    clock = clock + 64'(sb.last_sleep / 2);
                end
                else
                begin
                    clock = clock + 64'(sb.last_sleep) + 64'($urandom_range(0, 3000));
                end
                send_item(OP_PACE, stamp, clock);
                tries++;
            end
            clock = clock + 64'($urandom_range(0, 2 * period));
        end
    endtask

    // Stimulus.
    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        item_ch.valid    = 1'b0;
        item_ch.opcode   = OP_PACE;
        item_ch.stamp    = '0;
        item_ch.now_time = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        send_idle        = 24;
        recv_idle        = 45;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Pacing disabled after reset; the rebase opcode still counts.
        send_item(OP_PACE, 64'd1000, 64'd5000);
        send_item(OP_REBASE, 64'd0, 64'd0);
        settle();
        write_reg(REG_ENABLE, 40'd1);

        // First item, repeat, short and quantum-limited waits, backward stamp,
        // jump past the threshold, and the stamp and clock extremes.
        send_item(OP_PACE, 64'd1000, 64'd5000);
        send_item(OP_PACE, 64'd1000, 64'd9000);
        send_item(OP_PACE, 64'd6001000, 64'd6000);
        send_item(OP_PACE, 64'd6001000, 64'd6004500);
        send_item(OP_PACE, 64'd40001000, 64'd6010000);
        send_item(OP_PACE, 64'd500, 64'd7000000);
        send_item(OP_PACE, 64'd2000000500, 64'd7000100);
        send_item(OP_REBASE, STAMP_MAX, STAMP_MAX);
        send_item(OP_PACE, STAMP_MAX, STAMP_MAX);
        send_item(OP_PACE, 64'd0, 64'd0);

        // Target saturates when the base clock sits near the top.
        send_item(OP_REBASE, 64'd0, 64'd0);
        send_item(OP_PACE, 64'd0, STAMP_MAX - 64'd5);
        send_item(OP_PACE, 64'd100, STAMP_MAX - 64'd5);
        send_item(OP_PACE, 64'd200, 64'd0);
        settle();

        // Dropping on, default quantum, zero tolerance.
        write_reg(REG_MAX_LATE, 40'd1000);
        write_reg(REG_QUANTUM, 40'd0);
        write_reg(REG_TOLERANCE, 40'd0);
        send_item(OP_REBASE, 64'd0, 64'd0);
        send_item(OP_PACE, 64'd1000, 64'd1000);
        send_item(OP_PACE, 64'd2000, 64'd10000);
        send_item(OP_PACE, 64'd3000, 64'd3500);
        send_item(OP_PACE, 64'd50000000, 64'd3500);
        send_item(OP_PACE, 64'd50000000, 64'd49999999);
        send_item(OP_PACE, 64'd50000000, 64'd50000000);
        settle();

        // Jump check off and every other register at its top value.
        write_reg(REG_JUMP, 40'd0);
        write_reg(REG_MAX_LATE, '1);
        write_reg(REG_QUANTUM, '1);
        write_reg(REG_TOLERANCE, '1);
        send_item(OP_PACE, 64'd50000000 + (64'd1 << 50), 64'd50000000);
        settle();

        // Turning pacing off forgets the base without counting a reset.
        write_reg(REG_ENABLE, 40'd0);
        write_reg(REG_ENABLE, 40'd1);
        send_item(OP_PACE, 64'd77, 64'd88);

        // Random phases under three idling patterns.
        for (int m = 0; m < 3; m++)
        begin
            send_idle = (m == 0) ? 24 : ((m == 1) ? 45 : 0);
            recv_idle = (m == 0) ? 45 : ((m == 1) ? 24 : 0);
            item_goal = items_sent + 240;
            while (items_sent < item_goal)
            begin
                settle();
                configure_random();
                repeat ($urandom_range(2, 5))
                begin
                    if ($urandom_range(99) < 80)
                    begin
                        run_stream($urandom_range(5, 30));
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 8))
                        begin
                            send_item(($urandom_range(3) == 0) ? OP_REBASE : OP_PACE,
                                      rand64(), rand64());
                        end
                    end
                end
            end
        end

        settle();
        repeat (10) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d result items never arrived", $time, sb.expected_q.size());
        end
        if (sb.errors == 0)
        begin
            $display("** timestamp_pacer: PASSED **");
        end
        else
        begin
            $display("** timestamp_pacer: FAILED **");
        end
        $finish;
    end

endmodule
